// File: hdl/glmd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the grid local minimum detector
package glmd_pkg;

  // input opcodes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } glmd_op_e;

  // configuration register indexes
  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } glmd_reg_e;

  // field widths
  localparam int HEIGHT_W = 4;
  localparam int POS_W    = 7;
  localparam int DIM_W    = 8;
  localparam int RISK_W   = 18;

  // register reset values
  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 8'd100;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 8'd100;

  // saturation limit of the running sum
  localparam logic [RISK_W-1:0] RISK_MAX = '1;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_LW    = 3;

  // one cell to be judged, with its neighbours as read from the line buffers
  typedef struct packed {
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic                first;
    logic                has_right;
    logic                has_up;
    logic                has_down;
    logic [HEIGHT_W-1:0] down_val;
    logic [HEIGHT_W-1:0] col0_val;
    logic [HEIGHT_W-1:0] up_val;
    logic [HEIGHT_W-1:0] right_val;
    logic                done;
  } glmd_item_t;

endpackage

// File: hdl/glmd_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module glmd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and read-first registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/glmd_front.sv
`timescale 1ns / 1ps
// front: accepts items, tracks the raster position, owns the line buffers
module glmd_front #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [glmd_pkg::HEIGHT_W-1:0]       height_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [glmd_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic [glmd_pkg::Q_LW-1:0]           fifo_level_i,
  output logic                                push_o,
  output glmd_pkg::glmd_item_t                push_item_o
);

  import glmd_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [DIM_W-1:0]    grid_width_q, grid_height_q;
  logic [DIM_W-1:0]    w, hh, hh_m1;
  logic [XW-1:0]       col_cnt_q, flush_idx_q;
  logic [YW-1:0]       row_cnt_q;
  logic                flush_pending_q;
  logic                s1_valid_q, s1_center_q;
  glmd_item_t          s1_item_q, item_d;
  logic [1:0][HEIGHT_W-1:0] col0_q;

  logic                accept, is_flush, pix_take, flush_take, emit;
  logic [XW-1:0]       x, x_plus;
  logic                last_col, last_row, center;
  logic [XW-1:0]       raddr0, raddr1;
  logic [HEIGHT_W-1:0] rdata0, rdata1;
  logic                we0, we1;

  // clamp the configured dimensions to the supported range
  always_comb begin
    if (grid_width_q == '0) begin
      w = DIM_W'(1);
    end else if (16'(grid_width_q) > 16'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = grid_width_q;
    end
    if (grid_height_q == '0) begin
      hh = DIM_W'(1);
    end else if (16'(grid_height_q) > 16'(MAX_HEIGHT)) begin
      hh = DIM_W'(MAX_HEIGHT);
    end else begin
      hh = grid_height_q;
    end
    hh_m1 = hh - DIM_W'(1);
  end

  // room for this transfer plus the one already in flight
  assign in_stall_o = (32'(fifo_level_i) + 32'(s1_valid_q)) >= Q_DEPTH;

  // classify the transfer
  assign accept     = in_valid_i && !in_stall_o;
  assign is_flush   = (opcode_i == OP_FLUSH);
  assign pix_take   = accept && !is_flush && !flush_pending_q;
  assign flush_take = accept && is_flush && flush_pending_q;
  assign emit       = flush_take || (pix_take && (row_cnt_q != '0));

  assign x        = flush_pending_q ? flush_idx_q : col_cnt_q;
  assign x_plus   = x + XW'(1);
  assign last_col = (16'(x) + 16'd1) == 16'(w);
  assign last_row = (16'(row_cnt_q) + 16'd1) == 16'(hh);
  // line holding the cell to report: previous row for pixels, last row for flush
  assign center   = flush_pending_q ? hh_m1[0] : ~row_cnt_q[0];

  // center line is read one to the right, the other line at the column
  assign raddr0 = center ? x : x_plus;
  assign raddr1 = center ? x_plus : x;
  assign we0    = pix_take && !row_cnt_q[0];
  assign we1    = pix_take && row_cnt_q[0];

  glmd_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (col_cnt_q),
    .wdata_i (height_i),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  glmd_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_WIDTH)) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (col_cnt_q),
    .wdata_i (height_i),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  // item description, registered alongside the read of the line buffers
  always_comb begin
    item_d           = '0;
    item_d.col       = POS_W'(x);
    item_d.first     = (x == '0);
    item_d.has_right = !last_col;
    item_d.col0_val  = col0_q[center];
    if (flush_pending_q) begin
      item_d.row      = POS_W'(hh_m1);
      item_d.has_up   = (hh_m1 != '0);
      item_d.has_down = 1'b0;
      item_d.done     = last_col;
    end else begin
      item_d.row      = POS_W'(row_cnt_q - YW'(1));
      item_d.has_up   = 16'(row_cnt_q) >= 16'd2;
      item_d.has_down = 1'b1;
      item_d.down_val = height_i;
      item_d.done     = 1'b0;
    end
  end

  // configuration, raster counters and flush state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= GRID_WIDTH_RST;
      grid_height_q   <= GRID_HEIGHT_RST;
      col_cnt_q       <= '0;
      row_cnt_q       <= '0;
      flush_pending_q <= 1'b0;
      flush_idx_q     <= '0;
      s1_valid_q      <= 1'b0;
    end else begin
      s1_valid_q <= emit;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
          REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
          default:         grid_width_q  <= grid_width_q;
        endcase
        col_cnt_q       <= '0;
        row_cnt_q       <= '0;
        flush_pending_q <= 1'b0;
        flush_idx_q     <= '0;
      end else if (pix_take) begin
        if (last_col) begin
          col_cnt_q <= '0;
          if (last_row) begin
            flush_pending_q <= 1'b1;
            flush_idx_q     <= '0;
          end else begin
            row_cnt_q <= row_cnt_q + YW'(1);
          end
        end else begin
          col_cnt_q <= col_cnt_q + XW'(1);
        end
      end else if (flush_take) begin
        if (last_col) begin
          col_cnt_q       <= '0;
          row_cnt_q       <= '0;
          flush_pending_q <= 1'b0;
          flush_idx_q     <= '0;
        end else begin
          flush_idx_q <= flush_idx_q + XW'(1);
        end
      end
    end
  end

  // first column of each line kept aside for the start of the next row
  always_ff @(posedge clk_i) begin
    if (pix_take && (col_cnt_q == '0)) begin
      col0_q[row_cnt_q[0]] <= height_i;
    end
    if (emit) begin
      s1_item_q   <= item_d;
      s1_center_q <= center;
    end
  end

  // merge read data into the queued item
  always_comb begin
    push_item_o           = s1_item_q;
    push_item_o.right_val = s1_center_q ? rdata1 : rdata0;
    push_item_o.up_val    = s1_center_q ? rdata0 : rdata1;
  end
  assign push_o = s1_valid_q;

  // column counter rests at zero during the flush phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_pending_q |-> (col_cnt_q == '0))
    else $error("column counter moved while flushing");

  // a flush before the grid is complete makes no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && is_flush && !flush_pending_q) |=> !s1_valid_q)
    else $error("early flush produced a result");

  // the queue never gets more than it can hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fifo_level_i) + 32'(s1_valid_q)) <= Q_DEPTH)
    else $error("queue overcommitted");

endmodule

// File: hdl/glmd_fifo.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back
module glmd_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  glmd_pkg::glmd_item_t        push_item_i,
  input  logic                        pop_i,
  output logic                        head_valid_o,
  output glmd_pkg::glmd_item_t        head_item_o,
  output logic [glmd_pkg::Q_LW-1:0]   level_o
);

  import glmd_pkg::*;

  glmd_item_t        slot_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_LW-1:0]   level_q;

  assign head_valid_o = (level_q != '0);
  assign head_item_o  = slot_q[rd_ptr_q];
  assign level_o      = level_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + Q_LW'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - Q_LW'(1);
      end
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(level_q) < Q_DEPTH) || pop_i)
    else $error("push into full queue");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (level_q != '0))
    else $error("pop from empty queue");

  // pointers agree with the fill level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(level_q) < Q_DEPTH) |-> (Q_AW'(wr_ptr_q - rd_ptr_q) == Q_AW'(level_q)))
    else $error("queue pointers out of step");

endmodule

// File: hdl/glmd_back.sv
`timescale 1ns / 1ps
// back: sliding row window, neighbour compares, running sum and output register
module glmd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          head_valid_i,
  input  glmd_pkg::glmd_item_t          head_item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [glmd_pkg::POS_W-1:0]    col_o,
  output logic [glmd_pkg::POS_W-1:0]    row_o,
  output logic [glmd_pkg::HEIGHT_W-1:0] cell_height_o,
  output logic                          is_low_o,
  output logic [glmd_pkg::RISK_W-1:0]   risk_total_o,
  output logic                          frame_done_o
);

  import glmd_pkg::*;

  logic [HEIGHT_W-1:0] win_mid_q, win_right_q;
  logic [RISK_W-1:0]   risk_q, risk_d;
  logic                out_valid_q;
  logic [POS_W-1:0]    col_q, row_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                low_q, done_q;
  logic [RISK_W-1:0]   risk_out_q;

  logic [HEIGHT_W-1:0] left, mid;
  logic                low;
  logic [RISK_W:0]     sum;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  // neighbour compares for the head item
  always_comb begin
    mid  = head_item_i.first ? head_item_i.col0_val : win_right_q;
    left = win_mid_q;
    low  = 1'b1;
    if (!head_item_i.first && (left <= mid)) begin
      low = 1'b0;
    end
    if (head_item_i.has_right && (head_item_i.right_val <= mid)) begin
      low = 1'b0;
    end
    if (head_item_i.has_up && (head_item_i.up_val <= mid)) begin
      low = 1'b0;
    end
    if (head_item_i.has_down && (head_item_i.down_val <= mid)) begin
      low = 1'b0;
    end
    // saturating running sum of height plus one
    sum = {1'b0, risk_q} + (RISK_W+1)'(mid) + (RISK_W+1)'(1);
    if (!low) begin
      risk_d = risk_q;
    end else if (sum[RISK_W]) begin
      risk_d = RISK_MAX;
    end else begin
      risk_d = sum[RISK_W-1:0];
    end
  end

  // control state: sum and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      risk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        risk_q <= '0;
      end else if (pop_o) begin
        risk_q <= head_item_i.done ? '0 : risk_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window shift and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_mid_q   <= mid;
      win_right_q <= head_item_i.right_val;
      col_q       <= head_item_i.col;
      row_q       <= head_item_i.row;
      height_q    <= mid;
      low_q       <= low;
      done_q      <= head_item_i.done;
      risk_out_q  <= risk_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign col_o         = col_q;
  assign row_o         = row_q;
  assign cell_height_o = height_q;
  assign is_low_o      = low_q;
  assign risk_total_o  = risk_out_q;
  assign frame_done_o  = done_q;

  // the sum starts over after the last cell of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_item_i.done) |=> (risk_q == '0))
    else $error("sum not cleared at end of frame");

  // a cell that is not low leaves the sum alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !low && !head_item_i.done && !restart_i) |=> (risk_q == $past(risk_q)))
    else $error("sum changed on a cell that is not low");

  // the reported total matches the kept sum unless the frame just ended or a restart came
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !head_item_i.done && !restart_i) |=> (risk_total_o == risk_q))
    else $error("reported total differs from kept sum");

endmodule

// File: hdl/grid_local_minimum_detector_unit.sv
`timescale 1ns / 1ps
// top level of the grid local minimum detector
// Heights enter in raster order, one cell per transfer, and each cell of the previous
// row comes out once its lower neighbour has arrived; flush transfers then emit the last
// row, the final one marked frame_done. The block takes one transfer per clock cycle
// when the output is not stalled; a transfer reaches its result through the registered
// read of the line buffer rams, the queue and the output register. A four-entry queue
// sits between the input side and the result side, so input keeps flowing until the
// queue fills while the output is stalled. The line buffers need no clearing after
// reset. Write the registers only while the block is idle.
module grid_local_minimum_detector_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [glmd_pkg::HEIGHT_W-1:0] height_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [glmd_pkg::DIM_W-1:0]    cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [glmd_pkg::POS_W-1:0]    col_o,
  output logic [glmd_pkg::POS_W-1:0]    row_o,
  output logic [glmd_pkg::HEIGHT_W-1:0] cell_height_o,
  output logic                          is_low_o,
  output logic [glmd_pkg::RISK_W-1:0]   risk_total_o,
  output logic                          frame_done_o
);

  import glmd_pkg::*;

  logic              push, pop, head_valid;
  glmd_item_t        push_item, head_item;
  logic [Q_LW-1:0]   level;

  // input side
  glmd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .height_i     (height_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_level_i (level),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  // decoupling queue
  glmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .level_o      (level)
  );

  // result side
  glmd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (cfg_we_i),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .col_o         (col_o),
    .row_o         (row_o),
    .cell_height_o (cell_height_o),
    .is_low_o      (is_low_o),
    .risk_total_o  (risk_total_o),
    .frame_done_o  (frame_done_o)
  );

endmodule
